// ===== hdl/mlcd_pkg.sv =====
// Shared types and constants for the monochrome LCD capture block.
package mlcd_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Configuration register indexes.
    localparam logic [2:0] CFG_COLOR_CLEAR     = 3'd0;
    localparam logic [2:0] CFG_COLOR_SET       = 3'd1;
    localparam logic [2:0] CFG_BYTES_PER_LINE  = 3'd2;
    localparam logic [2:0] CFG_LINES_PER_FRAME = 3'd3;

    localparam logic [15:0] RST_COLOR_CLEAR     = 16'd40695;
    localparam logic [15:0] RST_COLOR_SET       = 16'd36467;
    localparam logic [7:0]  RST_BYTES_PER_LINE  = 8'd120;
    localparam logic [9:0]  RST_LINES_PER_FRAME = 10'd160;

    // One captured byte with its placement, passed from front to back.
    typedef struct packed {
        logic [7:0]  data;
        logic [10:0] row;
        logic [9:0]  col_base;
        logic        frame_done;
    } t_byte_rec;

endpackage

// ===== hdl/mlcd_queue.sv =====
// Short register queue of captured bytes between the front and back parts.
module mlcd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mlcd_pkg::t_byte_rec i_wr_rec,
    input  logic                i_pop,
    output mlcd_pkg::t_byte_rec o_rd_rec,
    output logic                o_full,
    output logic                o_empty
);

    mlcd_pkg::t_byte_rec        r_mem [mlcd_pkg::QDEPTH];
    logic [mlcd_pkg::QAW-1:0]   r_wr, n_wr;
    logic [mlcd_pkg::QAW-1:0]   r_rd, n_rd;
    logic [mlcd_pkg::QAW:0]     r_count, n_count;

    assign o_full   = (r_count == (mlcd_pkg::QAW+1)'(mlcd_pkg::QDEPTH));
    assign o_empty  = (r_count == '0);
    assign o_rd_rec = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wr_rec;
        end
    end

endmodule

// ===== hdl/mlcd_front.sv =====
// Front part: follows the sync and pixel clock levels and places each captured byte.
module mlcd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_vsync,
    input  logic                i_hsync,
    input  logic                i_pclk,
    input  logic [7:0]          i_data,
    input  logic [7:0]          i_bytes_per_line,
    input  logic [9:0]          i_lines_per_frame,
    output logic                o_push,
    output mlcd_pkg::t_byte_rec o_rec
);

    localparam logic [2:0] PH_WAIT_VLOW  = 3'd0;
    localparam logic [2:0] PH_WAIT_VHIGH = 3'd1;
    localparam logic [2:0] PH_WAIT_HHIGH = 3'd2;
    localparam logic [2:0] PH_WAIT_HLOW  = 3'd3;
    localparam logic [2:0] PH_WAIT_PHIGH = 3'd4;
    localparam logic [2:0] PH_WAIT_PLOW  = 3'd5;

    logic [2:0] r_phase, n_phase;
    logic [9:0] r_line, n_line;
    logic [7:0] r_byte, n_byte;

    logic       line_end;
    logic       frame_end;
    logic [7:0] half;
    logic       upper;
    logic [7:0] col_byte;

    assign line_end  = ({1'b0, r_byte} + 9'd1) >= {1'b0, i_bytes_per_line};
    assign frame_end = line_end && (({1'b0, r_line} + 11'd1) >= {1'b0, i_lines_per_frame});
    assign half      = {1'b0, i_bytes_per_line[7:1]};
    assign upper     = (r_byte >= half);
    assign col_byte  = upper ? (r_byte - half) : r_byte;

    assign o_push           = i_accept && (r_phase == PH_WAIT_PLOW) && !i_pclk;
    assign o_rec.data       = i_data;
    assign o_rec.row        = {r_line, upper};
    assign o_rec.col_base   = {col_byte[6:0], 3'b000};
    assign o_rec.frame_done = frame_end;

    always_comb begin
        n_phase = r_phase;
        n_line  = r_line;
        n_byte  = r_byte;
        if (i_accept) begin
            case (r_phase)
                PH_WAIT_VHIGH: begin
                    if (i_vsync) begin
                        n_line  = '0;
                        n_byte  = '0;
                        n_phase = PH_WAIT_HHIGH;
                    end
                end
                PH_WAIT_HHIGH: begin
                    if (i_hsync) begin
                        n_phase = PH_WAIT_HLOW;
                    end
                end
                PH_WAIT_HLOW: begin
                    if (!i_hsync) begin
                        n_byte  = '0;
                        n_phase = PH_WAIT_PHIGH;
                    end
                end
                PH_WAIT_PHIGH: begin
                    if (i_pclk) begin
                        n_phase = PH_WAIT_PLOW;
                    end
                end
                PH_WAIT_PLOW: begin
                    if (!i_pclk) begin
                        if (!line_end) begin
                            n_byte  = r_byte + 8'd1;
                            n_phase = PH_WAIT_PHIGH;
                        end else begin
                            n_byte = '0;
                            if (frame_end) begin
                                n_line  = '0;
                                n_phase = PH_WAIT_VLOW;
                            end else begin
                                n_line  = r_line + 10'd1;
                                n_phase = PH_WAIT_HHIGH;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = i_vsync ? PH_WAIT_VLOW : PH_WAIT_VHIGH;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT_VLOW;
            r_line  <= '0;
            r_byte  <= '0;
        end else begin
            r_phase <= n_phase;
            r_line  <= n_line;
            r_byte  <= n_byte;
        end
    end

endmodule

// ===== hdl/mlcd_back.sv =====
// Back part: expands each queued byte into eight pixels, most significant bit first.
module mlcd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mlcd_pkg::t_byte_rec i_rec,
    input  logic                i_empty,
    output logic                o_pop,
    input  logic [15:0]         i_color_clear,
    input  logic [15:0]         i_color_set,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [15:0]         o_value,
    output logic [10:0]         o_row,
    output logic [9:0]          o_col,
    output logic                o_frame_done,
    output logic                o_last
);

    mlcd_pkg::t_byte_rec r_rec;
    logic                r_busy;
    logic [2:0]          r_k;
    logic                take;
    logic                need;

    assign take  = r_busy && i_ready;
    assign need  = !r_busy || (take && (r_k == 3'd7));
    assign o_pop = need && !i_empty;

    assign o_valid      = r_busy;
    assign o_value      = r_rec.data[3'd7 - r_k] ? i_color_set : i_color_clear;
    assign o_row        = r_rec.row;
    assign o_col        = r_rec.col_base + {7'd0, r_k};
    assign o_frame_done = r_rec.frame_done;
    assign o_last       = (r_k == 3'd7);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
        end else if (need) begin
            r_busy <= !i_empty;
            r_k    <= '0;
        end else if (take) begin
            r_k <= r_k + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rec;
        end
    end

endmodule

// ===== hdl/mono_lcd_capture_to_rgb_pixels_core.sv =====
// Top level of the monochrome LCD capture block: configuration registers and the two parts.
//
//  Channel  Direction  Payload
//  s        in         tdata: vsync_level, hsync_level, pixel_clock_level, data_bus
//  m        out        tdata: pixel_value, pixel_row, pixel_column; tuser: frame_done;
//                      tlast: last_of_run
//  cfg      in         index (3 bits), data (16 bits), always ready
//
// A sample is taken every cycle while the byte queue has room; a captured byte
// yields eight pixels, one per cycle from the back part, so the pixel output sets
// the long-run rate of captured bytes. A sample reaches the queue in the cycle it
// is accepted, then the back part registers it to show its first pixel. Reset is
// synchronous; it empties the queue and returns the capture to waiting for vsync
// low. The back part stalls on i_m_tready alone, the front only on a full queue.
module mono_lcd_capture_to_rgb_pixels_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [0] vsync_level, [1] hsync_level,
                                     // [2] pixel_clock_level, [10:3] data_bus, zero fill
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [15:0] pixel_value, [26:16] pixel_row,
                                     // [36:27] pixel_column, zero fill
    output logic        o_m_tlast,   // last_of_run
    output logic        o_m_tuser,   // [0] frame_done
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_color_clear;
    logic [15:0] r_color_set;
    logic [7:0]  r_bytes_per_line;
    logic [9:0]  r_lines_per_frame;

    logic                s_accept;
    logic                push;
    logic                pop;
    logic                q_full;
    logic                q_empty;
    mlcd_pkg::t_byte_rec wr_rec;
    mlcd_pkg::t_byte_rec rd_rec;
    logic [15:0]         pix_value;
    logic [10:0]         pix_row;
    logic [9:0]          pix_col;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !q_full;
    assign s_accept    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_clear     <= mlcd_pkg::RST_COLOR_CLEAR;
            r_color_set       <= mlcd_pkg::RST_COLOR_SET;
            r_bytes_per_line  <= mlcd_pkg::RST_BYTES_PER_LINE;
            r_lines_per_frame <= mlcd_pkg::RST_LINES_PER_FRAME;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mlcd_pkg::CFG_COLOR_CLEAR:     r_color_clear     <= i_cfg_data;
                mlcd_pkg::CFG_COLOR_SET:       r_color_set       <= i_cfg_data;
                mlcd_pkg::CFG_BYTES_PER_LINE:  r_bytes_per_line  <= i_cfg_data[7:0];
                mlcd_pkg::CFG_LINES_PER_FRAME: r_lines_per_frame <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    mlcd_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (s_accept),
        .i_vsync           (i_s_tdata[0]),
        .i_hsync           (i_s_tdata[1]),
        .i_pclk            (i_s_tdata[2]),
        .i_data            (i_s_tdata[10:3]),
        .i_bytes_per_line  (r_bytes_per_line),
        .i_lines_per_frame (r_lines_per_frame),
        .o_push            (push),
        .o_rec             (wr_rec)
    );

    mlcd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wr_rec (wr_rec),
        .i_pop    (pop),
        .o_rd_rec (rd_rec),
        .o_full   (q_full),
        .o_empty  (q_empty)
    );

    mlcd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rec         (rd_rec),
        .i_empty       (q_empty),
        .o_pop         (pop),
        .i_color_clear (r_color_clear),
        .i_color_set   (r_color_set),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_value       (pix_value),
        .o_row         (pix_row),
        .o_col         (pix_col),
        .o_frame_done  (o_m_tuser),
        .o_last        (o_m_tlast)
    );

    assign o_m_tdata = {3'b000, pix_col, pix_row, pix_value};

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the monochrome LCD capture block, with a directed table and random frames.
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF      = 4;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_SAMPLES = 45;
    localparam int NUM_PHASES    = 8;
    localparam int MAX_REPORTS   = 10;

    // Index with no register behind it; writes to it must change nothing.
    localparam logic [2:0] CFG_SPARE_INDEX = 3'd5;

    typedef enum logic [2:0] {
        WAIT_VS_LOW, WAIT_VS_HIGH, WAIT_HS_HIGH, WAIT_HS_LOW, WAIT_PCLK_HIGH, WAIT_PCLK_LOW
    } t_capture_phase;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;
    typedef enum logic {ROW_SAMPLE, ROW_REG_WRITE} t_row_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       pclk;
        logic       hsync;
        logic       vsync;
    } t_bus_sample;

    typedef struct packed {
        logic [15:0] value;
        logic [10:0] row;
        logic [9:0]  column;
        logic        frame_done;
        logic        last_of_run;
    } t_pixel;

    typedef struct packed {
        t_row_kind   kind;
        logic [2:0]  reg_index;
        logic [15:0] reg_data;
        t_bus_sample smp;
        logic        typed;
        logic [15:0] first_value;
        logic [10:0] row;
        logic [9:0]  col_base;
        logic        frame_done;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;   // [0] vsync_level, [1] hsync_level,
                              // [2] pixel_clock_level, [10:3] data_bus, zero fill
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;   // [15:0] pixel_value, [26:16] pixel_row,
                              // [36:27] pixel_column, zero fill
    logic        o_m_tlast;   // last_of_run
    logic        o_m_tuser;   // [0] frame_done
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    // Mirror of the block's registers and capture state.
    logic [15:0]    reg_clear;
    logic [15:0]    reg_set;
    logic [7:0]     reg_bpl;
    logic [9:0]     reg_lpf;
    t_capture_phase cap_phase;
    logic [9:0]     line_idx;
    logic [7:0]     byte_idx;
    bit             byte_taken;

    t_pixel      expected_pixels[$];
    t_bus_sample bus_stim[$];
    t_dir_row    dir_rows[$];
    t_pixel      seen_pixel;
    t_pixel      want_pixel;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    mono_lcd_capture_to_rgb_pixels_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Pixel checker: every transaction on the output is matched to the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_pixel = '{value: o_m_tdata[15:0], row: o_m_tdata[26:16],
                           column: o_m_tdata[36:27], frame_done: o_m_tuser,
                           last_of_run: o_m_tlast};
            if (expected_pixels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("Unexpected pixel: value=%h row=%0d col=%0d frame_done=%b last=%b",
                             seen_pixel.value, seen_pixel.row, seen_pixel.column,
                             seen_pixel.frame_done, seen_pixel.last_of_run);
            end else begin
                want_pixel = expected_pixels.pop_front();
                if (seen_pixel !== want_pixel) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("Pixel mismatch at cycle %0d", cycle_count);
                        $display("  expected value=%h row=%0d col=%0d frame_done=%b last=%b",
                                 want_pixel.value, want_pixel.row, want_pixel.column,
                                 want_pixel.frame_done, want_pixel.last_of_run);
                        $display("  actual   value=%h row=%0d col=%0d frame_done=%b last=%b",
                                 seen_pixel.value, seen_pixel.row, seen_pixel.column,
                                 seen_pixel.frame_done, seen_pixel.last_of_run);
                    end
                end
            end
        end
    end

    // Advances the capture state by one bus sample and queues the pixels of a taken byte.
    task automatic decode_bus_sample(input t_bus_sample smp);
        bit          line_end;
        bit          frame_end;
        logic [7:0]  half;
        logic [10:0] row;
        logic [9:0]  col_base;
        int          col;
        t_pixel      px;
        byte_taken = 1'b0;
        case (cap_phase)
            WAIT_VS_HIGH: begin
                if (smp.vsync) begin
                    line_idx  = '0;
                    byte_idx  = '0;
                    cap_phase = WAIT_HS_HIGH;
                end
            end
            WAIT_HS_HIGH: begin
                if (smp.hsync) cap_phase = WAIT_HS_LOW;
            end
            WAIT_HS_LOW: begin
                if (!smp.hsync) begin
                    byte_idx  = '0;
                    cap_phase = WAIT_PCLK_HIGH;
                end
            end
            WAIT_PCLK_HIGH: begin
                if (smp.pclk) cap_phase = WAIT_PCLK_LOW;
            end
            WAIT_PCLK_LOW: begin
                if (!smp.pclk) begin
                    // A count of zero behaves as one, since the test is reached-or-passed.
                    line_end  = (int'(byte_idx) + 1) >= int'(reg_bpl);
                    frame_end = line_end && ((int'(line_idx) + 1) >= int'(reg_lpf));
                    half      = reg_bpl >> 1;
                    row       = {line_idx, 1'b0};
                    if (byte_idx < half) begin
                        col = int'(byte_idx) * 8;
                    end else begin
                        row[0] = 1'b1;
                        col    = (int'(byte_idx) - int'(half)) * 8;
                    end
                    col_base = col[9:0];
                    for (int k = 0; k < 8; k++) begin
                        px.value       = smp.data[7 - k] ? reg_set : reg_clear;
                        px.row         = row;
                        px.column      = col_base + 10'(k);
                        px.frame_done  = frame_end;
                        px.last_of_run = (k == 7);
                        expected_pixels.push_back(px);
                    end
                    byte_taken = 1'b1;
                    if (!line_end) begin
                        byte_idx  = byte_idx + 8'd1;
                        cap_phase = WAIT_PCLK_HIGH;
                    end else begin
                        byte_idx = '0;
                        if (frame_end) begin
                            line_idx  = '0;
                            cap_phase = WAIT_VS_LOW;
                        end else begin
                            line_idx  = line_idx + 10'd1;
                            cap_phase = WAIT_HS_HIGH;
                        end
                    end
                end
            end
            default: begin
                cap_phase = smp.vsync ? WAIT_VS_LOW : WAIT_VS_HIGH;
            end
        endcase
    endtask

    // Entered and left at a falling edge; leaves tvalid high for a following sample.
    task automatic send_sample(input t_bus_sample smp);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'b0, smp};
        do @(posedge i_clk); while (!o_s_tready);
        decode_bus_sample(smp);
        @(negedge i_clk);
    endtask

    // Leaves the write channel valid; the caller lowers it after the last write.
    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            mlcd_pkg::CFG_COLOR_CLEAR:     reg_clear = value;
            mlcd_pkg::CFG_COLOR_SET:       reg_set   = value;
            mlcd_pkg::CFG_BYTES_PER_LINE:  reg_bpl   = value[7:0];
            mlcd_pkg::CFG_LINES_PER_FRAME: reg_lpf   = value[9:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic wait_pixels_drained();
        do @(negedge i_clk); while (expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Queues one bus level, sometimes held for two samples and sometimes scrambled.
    task automatic queue_level(input logic vs, input logic hs, input logic pc);
        t_bus_sample smp;
        int          reps;
        reps = ($urandom_range(3) == 0) ? 2 : 1;
        repeat (reps) begin
            smp = {8'($urandom_range(255)), pc, hs, vs};
            if ($urandom_range(99) < 6) smp[2:0] = 3'($urandom_range(7));
            bus_stim.push_back(smp);
        end
    endtask

    function automatic t_dir_row bus_row(input logic vs, input logic hs, input logic pc,
                                         input logic [7:0] data);
        t_dir_row r;
        r       = '0;
        r.kind  = ROW_SAMPLE;
        r.smp   = {data, pc, hs, vs};
        return r;
    endfunction

    function automatic t_dir_row checked_row(input logic vs, input logic hs, input logic pc,
                                             input logic [7:0] data, input logic [15:0] value,
                                             input logic [10:0] row, input logic [9:0] col_base,
                                             input logic frame_done);
        t_dir_row r;
        r             = bus_row(vs, hs, pc, data);
        r.typed       = 1'b1;
        r.first_value = value;
        r.row         = row;
        r.col_base    = col_base;
        r.frame_done  = frame_done;
        return r;
    endfunction

    function automatic t_dir_row reg_row(input logic [2:0] index, input logic [15:0] value);
        t_dir_row r;
        r           = '0;
        r.kind      = ROW_REG_WRITE;
        r.reg_index = index;
        r.reg_data  = value;
        return r;
    endfunction

    task automatic run_phase(input t_idle_mode mode, input logic [15:0] clear_val,
                             input logic [15:0] set_val, input logic [7:0] bpl,
                             input logic [9:0] lpf, input bit pause_midway);
        int lines;
        int bytes;
        write_reg(mlcd_pkg::CFG_COLOR_CLEAR, clear_val);
        write_reg(mlcd_pkg::CFG_COLOR_SET, set_val);
        write_reg(mlcd_pkg::CFG_BYTES_PER_LINE, {8'd0, bpl});
        write_reg(mlcd_pkg::CFG_LINES_PER_FRAME, {6'd0, lpf});
        i_cfg_valid <= 1'b0;
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 69; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 69; end
            default:       begin send_idle_pct = 13; recv_stall_pct = 13; end
        endcase

        // Mostly well-formed frames with random content, cut off at the sample budget.
        bus_stim.delete();
        lines = (lpf == 0) ? 1 : int'(lpf);
        bytes = (bpl == 0) ? 1 : int'(bpl);
        while (bus_stim.size() < PHASE_SAMPLES) begin
            queue_level(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
            queue_level(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
            for (int ln = 0; ln < lines && bus_stim.size() < PHASE_SAMPLES; ln++) begin
                queue_level(1'($urandom_range(1)), 1'b1, 1'($urandom_range(1)));
                queue_level(1'($urandom_range(1)), 1'b0, 1'b0);
                for (int b = 0; b < bytes && bus_stim.size() < PHASE_SAMPLES; b++) begin
                    queue_level(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
                    queue_level(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0);
                end
            end
        end

        foreach (bus_stim[i]) begin
            send_sample(bus_stim[i]);
            if (pause_midway && i == PHASE_SAMPLES / 2) begin
                i_s_tvalid <= 1'b0;
                do @(negedge i_clk); while (expected_pixels.size() != 0);
            end
        end
        i_s_tvalid <= 1'b0;
        wait_pixels_drained();
    endtask

    initial begin
        bit bus_busy;
        bit cfg_busy;
        int base;

        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;

        reg_clear = mlcd_pkg::RST_COLOR_CLEAR;
        reg_set   = mlcd_pkg::RST_COLOR_SET;
        reg_bpl   = mlcd_pkg::RST_BYTES_PER_LINE;
        reg_lpf   = mlcd_pkg::RST_LINES_PER_FRAME;
        cap_phase = WAIT_VS_LOW;
        line_idx  = '0;
        byte_idx  = '0;

        // Reset settings: vsync already high is ignored, then one phase step per sample
        // even when several pins change together.
        dir_rows.push_back(bus_row(1'b1, 1'b1, 1'b1, 8'h00));
        dir_rows.push_back(bus_row(1'b0, 1'b1, 1'b1, 8'hFF));
        dir_rows.push_back(bus_row(1'b1, 1'b1, 1'b1, 8'h00));
        dir_rows.push_back(bus_row(1'b1, 1'b1, 1'b1, 8'h00));
        dir_rows.push_back(bus_row(1'b1, 1'b0, 1'b1, 8'h00));
        dir_rows.push_back(bus_row(1'b1, 1'b0, 1'b1, 8'h00));
        dir_rows.push_back(checked_row(1'b0, 1'b0, 1'b0, 8'hFF, mlcd_pkg::RST_COLOR_SET,
                                       11'd0, 10'd0, 1'b0));
        dir_rows.push_back(bus_row(1'b0, 1'b1, 1'b1, 8'h00));
        dir_rows.push_back(checked_row(1'b0, 1'b1, 1'b0, 8'h00, mlcd_pkg::RST_COLOR_CLEAR,
                                       11'd0, 10'd8, 1'b0));
        dir_rows.push_back(bus_row(1'b1, 1'b0, 1'b1, 8'hA5));
        dir_rows.push_back(bus_row(1'b1, 1'b0, 1'b0, 8'h5A));
        // Shrinking the line mid-way: the next byte closes the line and the frame.
        dir_rows.push_back(reg_row(mlcd_pkg::CFG_BYTES_PER_LINE, 16'd2));
        dir_rows.push_back(reg_row(mlcd_pkg::CFG_LINES_PER_FRAME, 16'd1));
        dir_rows.push_back(reg_row(mlcd_pkg::CFG_COLOR_SET, 16'hFFFF));
        dir_rows.push_back(reg_row(mlcd_pkg::CFG_COLOR_CLEAR, 16'h0000));
        dir_rows.push_back(bus_row(1'b0, 1'b0, 1'b1, 8'h00));
        dir_rows.push_back(checked_row(1'b0, 1'b0, 1'b0, 8'h81, 16'hFFFF, 11'd1, 10'd16, 1'b1));
        // A small frame: one line of two bytes, split over two rows.
        dir_rows.push_back(bus_row(1'b0, 1'b0, 1'b0, 8'h00));
        dir_rows.push_back(bus_row(1'b1, 1'b0, 1'b0, 8'h00));
        dir_rows.push_back(bus_row(1'b1, 1'b1, 1'b0, 8'h00));
        dir_rows.push_back(bus_row(1'b1, 1'b0, 1'b0, 8'h00));
        dir_rows.push_back(bus_row(1'b1, 1'b0, 1'b1, 8'h00));
        dir_rows.push_back(checked_row(1'b1, 1'b0, 1'b0, 8'hFF, 16'hFFFF, 11'd0, 10'd0, 1'b0));
        dir_rows.push_back(bus_row(1'b1, 1'b0, 1'b1, 8'h00));
        dir_rows.push_back(checked_row(1'b1, 1'b0, 1'b0, 8'h00, 16'h0000, 11'd1, 10'd0, 1'b1));
        // Unused register index, then zero counts, which behave as one.
        dir_rows.push_back(reg_row(CFG_SPARE_INDEX, 16'h1234));
        dir_rows.push_back(reg_row(mlcd_pkg::CFG_BYTES_PER_LINE, 16'd0));
        dir_rows.push_back(reg_row(mlcd_pkg::CFG_LINES_PER_FRAME, 16'd0));
        dir_rows.push_back(bus_row(1'b0, 1'b0, 1'b0, 8'h00));
        dir_rows.push_back(bus_row(1'b1, 1'b1, 1'b0, 8'h00));
        dir_rows.push_back(bus_row(1'b1, 1'b1, 1'b0, 8'h00));
        dir_rows.push_back(bus_row(1'b1, 1'b0, 1'b1, 8'h00));
        dir_rows.push_back(bus_row(1'b1, 1'b0, 1'b1, 8'h00));
        dir_rows.push_back(bus_row(1'b0, 1'b0, 1'b0, 8'hC3));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        bus_busy = 1'b0;
        cfg_busy = 1'b0;
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_REG_WRITE) begin
                if (bus_busy) begin
                    i_s_tvalid <= 1'b0;
                    bus_busy = 1'b0;
                    wait_pixels_drained();
                end
                write_reg(dir_rows[r].reg_index, dir_rows[r].reg_data);
                cfg_busy = 1'b1;
            end else begin
                if (cfg_busy) begin
                    i_cfg_valid <= 1'b0;
                    cfg_busy = 1'b0;
                end
                send_sample(dir_rows[r].smp);
                bus_busy = 1'b1;
                // Hand-written placement replaces the computed one for these rows.
                if (dir_rows[r].typed && byte_taken) begin
                    base = expected_pixels.size() - 8;
                    expected_pixels[base].value = dir_rows[r].first_value;
                    for (int k = 0; k < 8; k++) begin
                        expected_pixels[base + k].row        = dir_rows[r].row;
                        expected_pixels[base + k].column     = dir_rows[r].col_base + 10'(k);
                        expected_pixels[base + k].frame_done = dir_rows[r].frame_done;
                    end
                end
            end
        end
        i_s_tvalid <= 1'b0;
        wait_pixels_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                1: run_phase(IDLE_SENDER, 16'h0000, 16'hFFFF, 8'd254, 10'd1023, 1'b0);
                3: run_phase(IDLE_BOTH, 16'hFFFF, 16'h0000, 8'd255, 10'd2, 1'b0);
                default: run_phase(t_idle_mode'(p % 4), 16'($urandom_range(65535)),
                                   16'($urandom_range(65535)), 8'($urandom_range(1, 9)),
                                   10'($urandom_range(1, 4)), p == 2);
            endcase
        end

        repeat (SETTLE_CYCLES * 4) @(negedge i_clk);
        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
